// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files of the frame capture block
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/cfdt_pkg.sv =====
// types and constants of the decimating frame capture block
// no dependencies
`default_nettype none
package cfdt_pkg;

  localparam int PIX_W  = 8;
  localparam int CNT_W  = 8;
  localparam int ADDR_W = 13;
  localparam int REQ_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_PIXEL = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINARIZE  = 2'd1;

  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd128;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
  localparam logic [PIX_W-1:0] MIN_RST   = 8'hFF;
  localparam logic [PIX_W-1:0] MAX_RST   = 8'h00;

  typedef struct packed {
    logic              mem_write;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_data;
    logic [PIX_W-1:0]  max_brightness;
    logic [PIX_W-1:0]  min_brightness;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/cfdt_core.sv =====
// frame/line/column tracking, decimation, binarize and brightness tracking
// depends on cfdt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module cfdt_core #(
  parameter int FRAME_ROWS  = 144,
  parameter int FRAME_COLS  = 176,
  parameter int KEEP_ROWS   = 120,
  parameter int KEEP_COLS   = 160,
  parameter int STRIDE_LOG2 = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          fire,
  input  wire [cfdt_pkg::REQ_W-1:0]    req,
  input  wire [cfdt_pkg::PIX_W-1:0]    pix,
  input  wire [cfdt_pkg::PIX_W-1:0]    threshold,
  input  wire                          binarize_mode,
  output cfdt_pkg::result_t            res
);
  import cfdt_pkg::*;

  localparam logic [CNT_W-1:0] ROWS_C   = CNT_W'(FRAME_ROWS);
  localparam logic [CNT_W-1:0] COLS_C   = CNT_W'(FRAME_COLS);
  localparam logic [CNT_W-1:0] KROWS_C  = CNT_W'(KEEP_ROWS);
  localparam logic [CNT_W-1:0] KCOLS_C  = CNT_W'(KEEP_COLS);

  logic              frame_active_r, frame_active_nxt;
  logic [CNT_W-1:0]  row_count_r, row_count_nxt;
  logic              line_started_r, line_started_nxt;
  logic [CNT_W-1:0]  col_count_r, col_count_nxt;
  logic [ADDR_W-1:0] write_pointer_r, write_pointer_nxt;
  logic [PIX_W-1:0]  max_seen_r, max_seen_nxt;
  logic [PIX_W-1:0]  min_seen_r, min_seen_nxt;

  logic [CNT_W-1:0]  row_inc;
  logic [CNT_W-1:0]  new_row;
  logic [CNT_W-1:0]  cur_row;
  logic              new_row_kept;
  logic              pix_kept;
  logic              pix_taken;
  req_t              req_e;

  assign req_e        = req_t'(req);
  assign row_inc      = row_count_r + 1'b1;
  assign new_row      = ROWS_C - row_inc;
  assign cur_row      = ROWS_C - row_count_r;
  assign new_row_kept = (new_row < KROWS_C) && new_row[0];
  assign pix_taken    = frame_active_r && line_started_r && (col_count_r < COLS_C);
  assign pix_kept     = pix_taken && (cur_row < KROWS_C) && cur_row[0]
                        && (col_count_r < KCOLS_C) && col_count_r[0];

  always_comb begin
    frame_active_nxt  = frame_active_r;
    row_count_nxt     = row_count_r;
    line_started_nxt  = line_started_r;
    col_count_nxt     = col_count_r;
    write_pointer_nxt = write_pointer_r;
    max_seen_nxt      = max_seen_r;
    min_seen_nxt      = min_seen_r;
    res               = '0;
    unique case (req_e)
      REQ_FRAME: begin
        frame_active_nxt  = 1'b1;
        row_count_nxt     = '0;
        line_started_nxt  = 1'b0;
        col_count_nxt     = '0;
        write_pointer_nxt = '0;
        max_seen_nxt      = MAX_RST;
        min_seen_nxt      = MIN_RST;
      end
      REQ_LINE: begin
        if (frame_active_r && (row_count_r < ROWS_C)) begin
          row_count_nxt    = row_inc;
          line_started_nxt = 1'b1;
          col_count_nxt    = '0;
          if (new_row_kept) begin
            write_pointer_nxt = ADDR_W'(new_row[CNT_W-1:1]) << STRIDE_LOG2;
          end
        end else begin
          line_started_nxt = 1'b0;
        end
      end
      REQ_PIXEL: begin
        if (pix_taken) begin
          col_count_nxt = col_count_r + 1'b1;
        end
        if (pix_kept) begin
          res.mem_write     = 1'b1;
          res.mem_addr      = write_pointer_r;
          res.mem_data      = binarize_mode ? ((pix > threshold) ? PIX_WHITE : PIX_BLACK)
                                            : pix;
          write_pointer_nxt = write_pointer_r + 1'b1;
          if (max_seen_r < pix) begin
            max_seen_nxt = pix;
          end
          if (min_seen_r > pix) begin
            min_seen_nxt = pix;
          end
        end
      end
      default: begin
      end
    endcase
    res.max_brightness = max_seen_nxt;
    res.min_brightness = min_seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r  <= 1'b0;
      row_count_r     <= '0;
      line_started_r  <= 1'b0;
      col_count_r     <= '0;
      write_pointer_r <= '0;
      max_seen_r      <= MAX_RST;
      min_seen_r      <= MIN_RST;
    end else if (fire) begin
      frame_active_r  <= frame_active_nxt;
      row_count_r     <= row_count_nxt;
      line_started_r  <= line_started_nxt;
      col_count_r     <= col_count_nxt;
      write_pointer_r <= write_pointer_nxt;
      max_seen_r      <= max_seen_nxt;
      min_seen_r      <= min_seen_nxt;
    end
  end

  `ASSERT_IMPLIES(a_write_needs_line, clk, rst_n, fire && res.mem_write,
                  frame_active_r && line_started_r)
  `ASSERT_NEXT(a_write_orders_minmax, clk, rst_n, fire && res.mem_write,
               max_seen_r >= min_seen_r)
  `ASSERT_NEXT(a_frame_clears, clk, rst_n, fire && (req_e == REQ_FRAME),
               (row_count_r == '0) && (write_pointer_r == '0) && !line_started_r)
  `ASSERT_PROP(a_row_bound, clk, rst_n, row_count_r <= ROWS_C)

endmodule
`default_nettype wire

// ===== sv/camera_frame_decimate_threshold.sv =====
// an accepted input transaction is held in the input register and its result in
// the result register on out_*; one transaction per cycle while out_stall is low;
// both registers together let a new transaction in while a result waits to be taken
// reset (rst_n low, synchronous): no transaction in flight, threshold 128,
// raw mode, no frame open, max brightness 0 and min brightness 255
`default_nettype none
`include "assert_macros.svh"
module camera_frame_decimate_threshold #(
  parameter int FRAME_ROWS  = 144,
  parameter int FRAME_COLS  = 176,
  parameter int KEEP_ROWS   = 120,
  parameter int KEEP_COLS   = 160,
  parameter int STRIDE_LOG2 = 7
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [cfdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [cfdt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [cfdt_pkg::REQ_W-1:0]         in_req_type,
  input  wire [cfdt_pkg::PIX_W-1:0]         in_pixel_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_mem_write,
  output logic [cfdt_pkg::ADDR_W-1:0]       out_mem_addr,
  output logic [cfdt_pkg::PIX_W-1:0]        out_mem_data,
  output logic [cfdt_pkg::PIX_W-1:0]        out_max_brightness,
  output logic [cfdt_pkg::PIX_W-1:0]        out_min_brightness
);
  import cfdt_pkg::*;

  logic [PIX_W-1:0] threshold_r;
  logic             binarize_r;
  logic             in_valid_r;
  logic [REQ_W-1:0] in_req_r;
  logic [PIX_W-1:0] in_pix_r;
  logic             out_valid_r;
  result_t          out_r;
  result_t          core_res;
  logic             advance;
  logic             fire;
  logic             in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      binarize_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_THRESHOLD) begin
        threshold_r <= cfg_wdata[PIX_W-1:0];
      end else if (cfg_index == CFG_BINARIZE) begin
        binarize_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (in_take) begin
      in_req_r <= in_req_type;
      in_pix_r <= in_pixel_value;
    end
  end

  cfdt_core #(
    .FRAME_ROWS  (FRAME_ROWS),
    .FRAME_COLS  (FRAME_COLS),
    .KEEP_ROWS   (KEEP_ROWS),
    .KEEP_COLS   (KEEP_COLS),
    .STRIDE_LOG2 (STRIDE_LOG2)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .req           (in_req_r),
    .pix           (in_pix_r),
    .threshold     (threshold_r),
    .binarize_mode (binarize_r),
    .res           (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
    if (fire) begin
      out_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mem_write      = out_r.mem_write;
  assign out_mem_addr       = out_r.mem_addr;
  assign out_mem_data       = out_r.mem_data;
  assign out_max_brightness = out_r.max_brightness;
  assign out_min_brightness = out_r.min_brightness;

  `ASSERT_NEXT(a_fire_fills_out, clk, rst_n, fire, out_valid_r)
  `ASSERT_NEXT(a_blocked_input_held, clk, rst_n, in_valid_r && !advance,
               in_valid_r && $stable(in_req_r) && $stable(in_pix_r))
  `ASSERT_IMPLIES(a_no_stall_when_empty, clk, rst_n, !in_valid_r, !in_stall)

endmodule
`default_nettype wire

// ===== sim/cfdt_capture_check.sv =====
// result checker for the decimating frame capture block: follows the channels,
// predicts each result transaction from its own copy of the block state and compares
// depends on cfdt_pkg
module cfdt_capture_check
  import cfdt_pkg::*;
#(
  parameter int FRAME_ROWS  = 144,
  parameter int FRAME_COLS  = 176,
  parameter int KEEP_ROWS   = 120,
  parameter int KEEP_COLS   = 160,
  parameter int STRIDE_LOG2 = 7
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  wire [REQ_W-1:0]      in_req_type,
  input  wire [PIX_W-1:0]      in_pixel_value,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  wire                  out_mem_write,
  input  wire [ADDR_W-1:0]     out_mem_addr,
  input  wire [PIX_W-1:0]      out_mem_data,
  input  wire [PIX_W-1:0]      out_max_brightness,
  input  wire [PIX_W-1:0]      out_min_brightness,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   writes
);

  logic [PIX_W-1:0]  thresh_q;
  logic              bin_q;
  logic              frame_on;
  logic [CNT_W-1:0]  rows_seen;
  logic              line_open;
  logic [CNT_W-1:0]  cols_seen;
  logic [ADDR_W-1:0] wr_ptr;
  logic [PIX_W-1:0]  bright_max;
  logic [PIX_W-1:0]  bright_min;
  result_t           capture_q[$];

  task automatic predict_capture(input req_t req, input logic [PIX_W-1:0] pix,
                                 output result_t r);
    int row;
    int col;
    r = '0;
    case (req)
      REQ_FRAME: begin
        frame_on   = 1'b1;
        rows_seen  = '0;
        line_open  = 1'b0;
        cols_seen  = '0;
        wr_ptr     = '0;
        bright_max = MAX_RST;
        bright_min = MIN_RST;
      end
      REQ_LINE: begin
        if (frame_on && rows_seen < FRAME_ROWS) begin
          rows_seen = rows_seen + 1'b1;
          row = FRAME_ROWS - int'(rows_seen);
          line_open = 1'b1;
          cols_seen = '0;
          if (row < KEEP_ROWS && (row % 2) == 1) begin
            wr_ptr = ADDR_W'((row >> 1) << STRIDE_LOG2);
          end
        end else begin
          line_open = 1'b0;
        end
      end
      REQ_PIXEL: begin
        if (frame_on && line_open && cols_seen < FRAME_COLS) begin
          row = FRAME_ROWS - int'(rows_seen);
          col = int'(cols_seen);
          cols_seen = cols_seen + 1'b1;
          if (row < KEEP_ROWS && (row % 2) == 1 && col < KEEP_COLS && (col % 2) == 1) begin
            r.mem_write = 1'b1;
            r.mem_addr  = wr_ptr;
            if (bin_q) begin
              r.mem_data = (pix > thresh_q) ? PIX_WHITE : PIX_BLACK;
            end else begin
              r.mem_data = pix;
            end
            wr_ptr = wr_ptr + 1'b1;
            if (bright_max < pix) bright_max = pix;
            if (bright_min > pix) bright_min = pix;
          end
        end
      end
      default: ;
    endcase
    r.max_brightness = bright_max;
    r.min_brightness = bright_min;
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      thresh_q   = THRESHOLD_RST;
      bin_q      = 1'b0;
      frame_on   = 1'b0;
      rows_seen  = '0;
      line_open  = 1'b0;
      cols_seen  = '0;
      wr_ptr     = '0;
      bright_max = MAX_RST;
      bright_min = MIN_RST;
      capture_q.delete();
      fail_count = 0;
      checked    = 0;
      writes     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thresh_q = cfg_wdata[PIX_W-1:0];
          CFG_BINARIZE:  bin_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_capture(req_t'(in_req_type), in_pixel_value, want);
        capture_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (capture_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction, expected none, actual write %0d addr %0d data %0d",
                   $time, out_mem_write, out_mem_addr, out_mem_data);
        end else begin
          want = capture_q.pop_front();
          compare_field("mem_write", 16'(want.mem_write), 16'(out_mem_write));
          compare_field("mem_addr", 16'(want.mem_addr), 16'(out_mem_addr));
          compare_field("mem_data", 16'(want.mem_data), 16'(out_mem_data));
          compare_field("max_brightness", 16'(want.max_brightness), 16'(out_max_brightness));
          compare_field("min_brightness", 16'(want.min_brightness), 16'(out_min_brightness));
          if (want.mem_write) writes++;
        end
      end
    end
    pending = capture_q.size();
  end

endmodule

// ===== sim/camera_frame_decimate_threshold_tb.sv =====
// testbench top for camera_frame_decimate_threshold: drives camera streams and
// register writes under several idle and stall mixes, and gives the verdict
// depends on cfdt_pkg, cfdt_capture_check and the block itself
module camera_frame_decimate_threshold_tb;
  import cfdt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type;
  logic [PIX_W-1:0]      in_pixel_value;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_mem_write;
  logic [ADDR_W-1:0]     out_mem_addr;
  logic [PIX_W-1:0]      out_mem_data;
  logic [PIX_W-1:0]      out_max_brightness;
  logic [PIX_W-1:0]      out_min_brightness;

  int fail_count;
  int pending;
  int checked;
  int writes;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  logic [PIX_W-1:0] thresh_now = THRESHOLD_RST;

  camera_frame_decimate_threshold DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mem_write      (out_mem_write),
    .out_mem_addr       (out_mem_addr),
    .out_mem_data       (out_mem_data),
    .out_max_brightness (out_max_brightness),
    .out_min_brightness (out_min_brightness)
  );

  cfdt_capture_check capture_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mem_write      (out_mem_write),
    .out_mem_addr       (out_mem_addr),
    .out_mem_data       (out_mem_data),
    .out_max_brightness (out_max_brightness),
    .out_min_brightness (out_min_brightness),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked),
    .writes             (writes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // pixels cluster around the threshold so the strict compare is exercised
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return thresh_now;
      1: return thresh_now + 1'b1;
      2: return thresh_now - 1'b1;
      3: return PIX_BLACK;
      4: return PIX_WHITE;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input req_t req, input logic [PIX_W-1:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_pixel_value <= pix;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input bit deep);
    int nlines;
    int npix;
    int pick;
    send_item(REQ_FRAME, PIX_W'($urandom_range(255)));
    pick = $urandom_range(99);
    if (deep) nlines = $urandom_range(145, 147);
    else if (pick < 60) nlines = $urandom_range(1, 12);
    else nlines = $urandom_range(20, 30);
    for (int ln = 1; ln <= nlines; ln++) begin
      if ($urandom_range(99) < 3) begin
        send_item(req_t'($urandom_range(int'(REQ_NONE))), PIX_W'($urandom_range(255)));
      end
      send_item(REQ_LINE, PIX_W'($urandom_range(255)));
      pick = $urandom_range(99);
      // the first kept row gets a line longer than the frame width
      if (deep && ln == 25) npix = 180;
      else if (deep) npix = $urandom_range(0, 2);
      else if (pick < 85) npix = $urandom_range(0, 3);
      else if (pick < 99) npix = $urandom_range(4, 10);
      else npix = $urandom_range(158, 180);
      repeat (npix) send_item(REQ_PIXEL, pick_pixel());
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [PIX_W-1:0] thr, input logic mode,
                           input bit deep, input int n_items);
    int goal;
    int pick;
    drain();
    write_cfg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(255)));
    write_cfg(CFG_THRESHOLD, thr);
    write_cfg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(255)));
    write_cfg(CFG_BINARIZE, CFG_DATA_W'(mode));
    thresh_now     = thr;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = items_sent + n_items;
    if (deep) send_frame(1'b1);
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) send_frame(1'b0);
      else if (pick < 95) begin
        send_item(req_t'($urandom_range(int'(REQ_NONE))), PIX_W'($urandom_range(255)));
      end else drain();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_THRESHOLD;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_NONE;
    in_pixel_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // stream before any frame start, then a short frame and a restart
    send_item(REQ_PIXEL, 8'hA5);
    send_item(REQ_LINE, 8'h00);
    send_item(REQ_NONE, 8'hFF);
    send_item(REQ_FRAME, 8'h00);
    send_item(REQ_PIXEL, 8'h5A);
    send_item(REQ_LINE, 8'h00);
    send_item(REQ_PIXEL, 8'h00);
    send_item(REQ_PIXEL, 8'hFF);
    send_item(REQ_NONE, 8'h80);
    send_item(REQ_PIXEL, 8'h80);
    send_item(REQ_LINE, 8'hFF);
    send_item(REQ_PIXEL, 8'h7F);
    send_item(REQ_FRAME, 8'hFF);
    send_item(REQ_PIXEL, 8'h01);
    send_item(REQ_LINE, 8'h00);
    send_item(REQ_PIXEL, 8'hFE);
    send_item(REQ_NONE, 8'h00);

    run_phase(0, 0, 8'd0, 1'b1, 1'b1, 100);
    run_phase(49, 0, 8'd255, 1'b1, 1'b0, 40);
    run_phase(0, 49, PIX_W'($urandom_range(255)), 1'b0, 1'b0, 40);
    run_phase(27, 27, PIX_W'($urandom_range(255)), 1'b1, 1'b0, 40);
    run_phase(0, 0, PIX_W'($urandom_range(255)), 1'b0, 1'b0, 40);
    drain();

    $display("run covered %0d transactions with %0d frame-buffer writes,", checked, writes);
    $display("raw and binarize modes, thresholds 0 and 255, four idle and stall mixes");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cfdt_pkg.sv
sv/cfdt_core.sv
sv/camera_frame_decimate_threshold.sv
sim/cfdt_capture_check.sv
sim/camera_frame_decimate_threshold_tb.sv
